// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and a helper function of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned DefPoolBytes   = 65536;
  localparam int unsigned DefHeaderBytes = 16;
  localparam int unsigned DefMinBlock    = 32;

  localparam int unsigned TagW = 6;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusNoSpace = 2'd1;
  localparam logic [1:0] StatusBadFree = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  function automatic int unsigned clog2u(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((32'd1 << r) < v) r++;
    return r;
  endfunction

endpackage

// ===== sv/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two pool, tags kept in one RAM.
// ----------------------------------------------------------------------------
// Usage: a request enters on s_axis (tuser = operation, tdata = request_bytes
// and freed_address). Exactly one result leaves on m_axis per request
// (tdata = status and granted_address).
// One request is worked at a time. An allocate scans the tag RAM block by
// block (each block visited is read, then decided) and writes once per
// halving. A free takes one read and two writes per merge level. The tag
// RAM port is the limit: one access each cycle.
// After reset a clearing pass writes every tag, one slot a cycle
// (POOL_BYTES/MIN_BLOCK_BYTES slots, 2048 by default) before s_axis_tready
// rises. The result is held in an output register; while the receiver
// stalls, the next request is not taken until that result is gone, so no
// result is lost.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned POOL_BYTES      = DefPoolBytes,
  parameter int unsigned HEADER_BYTES    = DefHeaderBytes,
  parameter int unsigned MIN_BLOCK_BYTES = DefMinBlock
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_bytes[15:0], freed_address[31:16]
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], granted_address[17:2], zero
);

  localparam int unsigned Slots = POOL_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned SW1   = SW + 1;
  localparam int unsigned MinSh = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned TopOrder = $clog2(Slots);
  localparam int unsigned OW    = 5;
  localparam logic [OW-1:0] TopO = OW'(TopOrder);

  typedef enum logic [8:0] {
    StClear  = 9'b000000001,
    StIdle   = 9'b000000010,
    StARead  = 9'b000000100,
    StAChk   = 9'b000001000,
    StASplit = 9'b000010000,
    StFChk   = 9'b000100000,
    StFBRd   = 9'b001000000,
    StFBChk  = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [SW1-1:0] s_q, s_d, clr_q, clr_d;
  logic [OW-1:0]  k_q, k_d;
  logic [17:0]    need_q, need_d;
  logic           op_q, op_d;
  logic [1:0]     st_q, st_d;
  logic [15:0]    ga_q, ga_d;
  logic [SW1-1:0] b_q, b_d;

  logic           we;
  logic [SW-1:0]  addr;
  logic [TagW-1:0] wdata, rdata;

  bba_ram #(.Width(TagW), .Depth(Slots)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [OW-1:0] rk;
  logic [40:0]   rsize, hsize;
  logic [40:0]   off;
  logic [16:0]   fa_off;
  logic [SW1-1:0] step;

  always_comb begin
    rk     = rdata[OW-1:0] - OW'(1);
    rsize  = 41'(MIN_BLOCK_BYTES) << rk;
    hsize  = 41'(MIN_BLOCK_BYTES) << (k_q - OW'(1));
    off    = 41'(s_q) << MinSh;
    fa_off = 17'(s_axis_tdata[31:16]) - 17'(HEADER_BYTES);
    step   = SW1'(1) << rk;
  end

  always_comb begin
    state_d = state_q;
    s_d = s_q; clr_d = clr_q; k_d = k_q; need_d = need_q; op_d = op_q;
    st_d = st_q; ga_d = ga_q; b_d = b_q;
    we = 1'b0; addr = s_q[SW-1:0]; wdata = '0;
    unique case (state_q)
      StClear: begin
        we = 1'b1; addr = clr_q[SW-1:0];
        wdata = (clr_q == '0) ? TagW'(TopO + OW'(1)) : '0;
        clr_d = clr_q + SW1'(1);
        if (clr_q == SW1'(Slots - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tuser;
          st_d = StatusDone; ga_d = '0;
          if (s_axis_tuser == OpAlloc) begin
            need_d = 18'(s_axis_tdata[15:0]) + 18'(HEADER_BYTES);
            s_d = '0; state_d = StARead;
          end else begin
            s_d = SW1'(fa_off >> MinSh);
            if (s_axis_tdata[31:16] < 16'(HEADER_BYTES) ||
                (fa_off & 17'(MIN_BLOCK_BYTES - 1)) != '0 ||
                (41'(fa_off) >> MinSh) >= 41'(Slots)) begin
              st_d = StatusBadFree; state_d = StOut;
            end else begin
              addr = SW'(fa_off >> MinSh);
              state_d = StFChk;
            end
          end
        end
      end
      StARead: begin
        if (s_q >= SW1'(Slots)) begin
          st_d = StatusNoSpace; state_d = StOut;
        end else begin
          state_d = StAChk;
        end
      end
      StAChk: begin
        if (rdata[OW-1:0] == '0) begin
          s_d = s_q + SW1'(1); addr = SW'(s_q + SW1'(1)); state_d = StARead;
        end else if (!rdata[5] && rsize >= 41'(need_q)) begin
          k_d = rk; state_d = StASplit;
        end else begin
          s_d = s_q + step; addr = SW'(s_q + step); state_d = StARead;
        end
      end
      StASplit: begin
        if (k_q != '0 && hsize >= 41'(need_q)) begin
          k_d = k_q - OW'(1);
          we = 1'b1; addr = SW'(s_q + (SW1'(1) << (k_q - OW'(1))));
          wdata = TagW'(k_q);
        end else begin
          we = 1'b1; wdata = {1'b1, k_q + OW'(1)};
          ga_d = 16'(off + 41'(HEADER_BYTES));
          state_d = StOut;
        end
      end
      StFChk: begin
        if (rdata[OW-1:0] == '0 || !rdata[5]) begin
          st_d = StatusBadFree; state_d = StOut;
        end else begin
          k_d = rk; we = 1'b1; wdata = TagW'(rdata[OW-1:0]);
          if (rk >= TopO) begin
            state_d = StOut;
          end else begin
            b_d = s_q ^ (SW1'(1) << rk);
            state_d = StFBRd;
          end
        end
      end
      StFBRd: begin
        if (b_q >= SW1'(Slots)) begin
          state_d = StOut;
        end else begin
          addr = b_q[SW-1:0]; state_d = StFBChk;
        end
      end
      StFBChk: begin
        addr = b_q[SW-1:0];
        if (rdata != TagW'(k_q + OW'(1))) begin
          state_d = StOut;
        end else begin
          if (b_q < s_q) begin
            we = 1'b1; addr = s_q[SW-1:0]; wdata = '0;
            s_d = b_q;
          end else begin
            we = 1'b1; addr = b_q[SW-1:0]; wdata = '0;
          end
          k_d = k_q + OW'(1);
          state_d = StFBRd;
          b_d = (b_q < s_q ? b_q : s_q) ^ (SW1'(1) << (k_q + OW'(1)));
          need_d = 18'(1);
        end
      end
      StOut: begin
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // write the merged head tag on the step after a merge
    if (state_q == StFBRd && need_q == 18'(1) && op_q == OpFree) begin
      we = 1'b1; addr = s_q[SW-1:0]; wdata = TagW'(k_q + OW'(1));
      need_d = '0;
      if (k_q >= TopO) state_d = StOut;
      else state_d = StFBRd;
    end
  end

  // keep reads of the buddy from clashing with the head write: retry read
  logic fb_wrote_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fb_wrote_q <= 1'b0;
    else fb_wrote_q <= (state_q == StFBRd) && we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      s_q <= '0; k_q <= '0; need_q <= '0; op_q <= OpAlloc; b_q <= '0;
    end else begin
      state_q <= (state_q == StFBChk && fb_wrote_q) ? StFBRd : state_d;
      clr_q <= clr_d; s_q <= s_d; k_q <= k_d; op_q <= op_d; b_q <= b_d;
      need_q <= (state_q == StFBChk && fb_wrote_q) ? '0 : need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    ga_q <= ga_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {6'd0, ga_q, st_q};

endmodule

// ===== sv/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("request taken with result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != StatusDone |-> m_axis_tdata[17:2] == 16'd0)
    else $error("address on failure");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buddy block allocator. Requests go in on the
// slave stream and every transfer is predicted by a tag-level model of the
// pool kept here. Results coming out of the master stream are compared field
// by field, in order. Directed requests cover the corner cases. Random
// traffic is mostly well-formed alloc/free of live blocks with some noise.
// A long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int unsigned Slots     = DefPoolBytes / DefMinBlock;
  localparam int unsigned TopOrder  = 11;
  localparam int unsigned WatchLim  = 40000;
  localparam int unsigned HoldLen   = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // request_bytes[15:0], freed_address[31:16]
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // status[1:0], granted_address[17:2], zero

  logic [5:0]  pool_tags [Slots];
  result_t     pending_results [$];
  logic [15:0] live_blocks [$];
  int unsigned error_count;
  int unsigned idle_count;
  bit          no_idle;
  bit          hold_req;

  buddy_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic result_t grant_block(input logic [15:0] req);
    int unsigned need;
    int unsigned s;
    int unsigned k;
    result_t     r;
    need = req + DefHeaderBytes;
    s = 0;
    while (s < Slots) begin
      if (pool_tags[s][4:0] == 0) begin
        s++;
        continue;
      end
      k = pool_tags[s][4:0] - 1;
      if (!pool_tags[s][5] && (DefMinBlock << k) >= need) begin
        while (k > 0 && (DefMinBlock << (k - 1)) >= need) begin
          k--;
          pool_tags[s + (1 << k)] = 6'(k + 1);
        end
        pool_tags[s] = {1'b1, 5'(k + 1)};
        r.status = StatusDone;
        r.addr   = 16'(s * DefMinBlock + DefHeaderBytes);
        return r;
      end
      s += 1 << k;
    end
    r.status = StatusNoSpace;
    r.addr   = '0;
    return r;
  endfunction

  function automatic result_t release_block(input logic [15:0] fa);
    int unsigned off;
    int unsigned s;
    int unsigned k;
    int unsigned b;
    result_t     r;
    r.addr   = '0;
    r.status = StatusBadFree;
    if (fa < DefHeaderBytes) return r;
    off = fa - DefHeaderBytes;
    if (off % DefMinBlock != 0 || off / DefMinBlock >= Slots) return r;
    s = off / DefMinBlock;
    if (pool_tags[s][4:0] == 0 || !pool_tags[s][5]) return r;
    k = pool_tags[s][4:0] - 1;
    pool_tags[s] = 6'(k + 1);
    while (k < TopOrder) begin
      b = s ^ (1 << k);
      if (b >= Slots || pool_tags[b] != 6'(k + 1)) break;
      pool_tags[s] = '0;
      pool_tags[b] = '0;
      k++;
      s = (s < b) ? s : b;
      pool_tags[s] = 6'(k + 1);
    end
    r.status = StatusDone;
    return r;
  endfunction

  // hold the item until transferred, then log its predicted result
  task automatic send_request(input logic op, input logic [15:0] req,
                              input logic [15:0] fa);
    result_t r;
    int      idx [$];
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {fa, req};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    if (op == OpAlloc) r = grant_block(req);
    else r = release_block(fa);
    pending_results.push_back(r);
    if (r.status == StatusDone) begin
      if (op == OpAlloc) live_blocks.push_back(r.addr);
      else begin
        idx = live_blocks.find_first_index(x) with (x == fa);
        if (idx.size() != 0) live_blocks.delete(idx[0]);
      end
    end
    if (!no_idle && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HoldLen) @(posedge clk_i);
      hold_req = 1'b0;
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= 18);
  end

  always @(negedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== exp_r.status)
          report($sformatf("status %0d, want %0d", m_axis_tdata[1:0], exp_r.status));
        if (m_axis_tdata[17:2] !== exp_r.addr)
          report($sformatf("address %h, want %h", m_axis_tdata[17:2], exp_r.addr));
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count = 0;
    else if (rst_ni)
      idle_count++;
    if (idle_count >= WatchLim) begin
      $display("buddy_block_allocator test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OpAlloc, 16'd65520, 16'd0);      // whole pool
    send_request(OpAlloc, 16'd0, 16'd0);          // no space left
    send_request(OpFree, 16'd0, 16'd16);          // frees the pool
    send_request(OpAlloc, 16'd65521, 16'd0);      // larger than pool
    send_request(OpAlloc, 16'd65535, 16'hFFFF);
    send_request(OpAlloc, 16'd0, 16'd0);          // zero bytes, min block
    send_request(OpAlloc, 16'd16, 16'd0);
    send_request(OpAlloc, 16'd17, 16'd0);
    send_request(OpAlloc, 16'd1000, 16'd0);
    send_request(OpFree, 16'hFFFF, 16'd0);        // below header
    send_request(OpFree, 16'd0, 16'd15);
    send_request(OpFree, 16'd0, 16'd17);          // misaligned
    send_request(OpFree, 16'd0, 16'hFFFF);
    send_request(OpFree, 16'd0, 16'd65520);       // inside a free block
    send_request(OpFree, 16'd0, 16'd48);          // used
    send_request(OpFree, 16'd0, 16'd48);          // already free
    send_request(OpFree, 16'd0, 16'd16);
    send_request(OpFree, 16'd0, 16'd80);
    send_request(OpFree, 16'd0, 16'd144);         // inside a merged free block
    send_request(OpAlloc, 16'd32767, 16'd0);
    send_request(OpAlloc, 16'd32752, 16'd0);
    send_request(OpFree, 16'd0, 16'd16);
  endtask

  task automatic random_item();
    logic [15:0] req;
    if ($urandom_range(99) < 75) begin
      if (live_blocks.size() != 0 &&
          (live_blocks.size() > 40 || $urandom_range(99) < 45)) begin
        send_request(OpFree, 16'($urandom),
                     live_blocks[$urandom_range(live_blocks.size() - 1)]);
      end else begin
        case ($urandom_range(9))
          0:       req = 16'($urandom);
          1, 2:    req = 16'($urandom_range(4000));
          default: req = 16'($urandom_range(120));
        endcase
        send_request(OpAlloc, req, 16'($urandom));
      end
    end else begin
      send_request(1'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random(input int unsigned n);
    repeat (n) random_item();
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    repeat (150) random_item();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (30) random_item();
  endtask

  initial begin
    error_count   = 0;
    idle_count    = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    foreach (pool_tags[i]) pool_tags[i] = '0;
    pool_tags[0] = 6'(TopOrder + 1);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    test_steady_stream();
    test_backpressure();
    test_random(500);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("buddy_block_allocator test passed");
    end else begin
      $display("buddy_block_allocator test failed");
    end
    $finish;
  end

endmodule
